### src/bqg_pkg.sv
package bqg_pkg;

    localparam int MAX_GLYPHS = 4096;
    localparam int CNT_W      = $clog2(MAX_GLYPHS + 1);
    localparam int VN_W       = 14;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 32;
    localparam int SIZE_W     = 31;
    localparam int TEX_W      = 16;
    localparam int COL_W      = 32;
    localparam int PROD_W     = CFG_W + SIZE_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_BIAS = 16384;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic signed [CFG_W-1:0] UNIT_VEC = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RIGHT_X = 3'd0,
        REG_RIGHT_Y = 3'd1,
        REG_RIGHT_Z = 3'd2,
        REG_UP_X    = 3'd3,
        REG_UP_Y    = 3'd4,
        REG_UP_Z    = 3'd5
    } cfg_reg_t;

    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TR = 2'd2;
    localparam logic [1:0] CORNER_TL = 2'd3;

    typedef struct packed {
        logic signed [CFG_W-1:0] right_x;
        logic signed [CFG_W-1:0] right_y;
        logic signed [CFG_W-1:0] right_z;
        logic signed [CFG_W-1:0] up_x;
        logic signed [CFG_W-1:0] up_y;
        logic signed [CFG_W-1:0] up_z;
    } cam_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  center_x;
        logic signed [POS_W-1:0]  center_y;
        logic signed [POS_W-1:0]  center_z;
        logic signed [PROD_W-1:0] prod_rx;
        logic signed [PROD_W-1:0] prod_ry;
        logic signed [PROD_W-1:0] prod_rz;
        logic signed [PROD_W-1:0] prod_ux;
        logic signed [PROD_W-1:0] prod_uy;
        logic signed [PROD_W-1:0] prod_uz;
        logic [TEX_W-1:0]         tex_ul;
        logic [TEX_W-1:0]         tex_vb;
        logic [TEX_W-1:0]         tex_ur;
        logic [TEX_W-1:0]         tex_vt;
        logic [COL_W-1:0]         color;
        logic [VN_W-1:0]          base;
    } glyph_rec_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [TEX_W-1:0]        vert_u;
        logic [TEX_W-1:0]        vert_v;
        logic [COL_W-1:0]        vert_color;
        logic [VN_W-1:0]         vertex_number;
        logic                    tri_valid;
        logic [VN_W-1:0]         tri_first;
        logic [VN_W-1:0]         tri_second;
        logic [VN_W-1:0]         tri_third;
        logic                    last_corner;
    } vertex_t;

endpackage

### src/billboard_quad_generator_core.sv
// Expands each glyph instance into four camera-facing quad vertices, emitted in the order
// bottom-left, bottom-right, top-right, top-left, one vertex per cycle while the vertex
// output is not stalled. Instances are taken on back-to-back cycles into a multiply stage
// and a two-entry queue, so the input keeps flowing while vertices are stalled until these
// fill; an instance beyond the batch limit is accepted and yields nothing. An accepted
// instance passes the multiply stage register, the queue, the current-instance register and
// the vertex output register before its first vertex appears. Camera vectors are written
// through the configuration channel, which is always ready; the user must write them only
// while no transaction is in flight, as the block itself does not enforce this.
module billboard_quad_generator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bqg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bqg_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_batch_start,
    input  logic signed [bqg_pkg::POS_W-1:0]      s_center_x,
    input  logic signed [bqg_pkg::POS_W-1:0]      s_center_y,
    input  logic signed [bqg_pkg::POS_W-1:0]      s_center_z,
    input  logic [bqg_pkg::SIZE_W-1:0]            s_glyph_width,
    input  logic [bqg_pkg::SIZE_W-1:0]            s_glyph_height,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_u_left,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_v_bottom,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_u_right,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_v_top,
    input  logic [bqg_pkg::COL_W-1:0]             s_color_rgba,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bqg_pkg::POS_W-1:0]      m_pos_x,
    output logic signed [bqg_pkg::POS_W-1:0]      m_pos_y,
    output logic signed [bqg_pkg::POS_W-1:0]      m_pos_z,
    output logic [bqg_pkg::TEX_W-1:0]             m_vert_u,
    output logic [bqg_pkg::TEX_W-1:0]             m_vert_v,
    output logic [bqg_pkg::COL_W-1:0]             m_vert_color,
    output logic [bqg_pkg::VN_W-1:0]              m_vertex_number,
    output logic                                  m_tri_valid,
    output logic [bqg_pkg::VN_W-1:0]              m_tri_first,
    output logic [bqg_pkg::VN_W-1:0]              m_tri_second,
    output logic [bqg_pkg::VN_W-1:0]              m_tri_third,
    output logic                                  m_last_corner
);
    import bqg_pkg::*;

    cam_cfg_t   cfg_reg, cfg_next;
    logic       fe_valid, fe_ready;
    glyph_rec_t fe_rec;
    logic       q_valid, q_ready;
    glyph_rec_t q_rec;
    vertex_t    m_vert;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RIGHT_X: cfg_next.right_x = cfg_data;
                REG_RIGHT_Y: cfg_next.right_y = cfg_data;
                REG_RIGHT_Z: cfg_next.right_z = cfg_data;
                REG_UP_X:    cfg_next.up_x    = cfg_data;
                REG_UP_Y:    cfg_next.up_y    = cfg_data;
                REG_UP_Z:    cfg_next.up_z    = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.right_x <= UNIT_VEC;
            cfg_reg.right_y <= '0;
            cfg_reg.right_z <= '0;
            cfg_reg.up_x    <= '0;
            cfg_reg.up_y    <= UNIT_VEC;
            cfg_reg.up_z    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bqg_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cam_cfg        (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_batch_start  (s_batch_start),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_center_z     (s_center_z),
        .s_glyph_width  (s_glyph_width),
        .s_glyph_height (s_glyph_height),
        .s_tex_u_left   (s_tex_u_left),
        .s_tex_v_bottom (s_tex_v_bottom),
        .s_tex_u_right  (s_tex_u_right),
        .s_tex_v_top    (s_tex_v_top),
        .s_color_rgba   (s_color_rgba),
        .fe_valid       (fe_valid),
        .fe_ready       (fe_ready),
        .fe_rec         (fe_rec)
    );

    bqg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_rec    (fe_rec),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_rec   (q_rec)
    );

    bqg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_rec   (q_rec),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_vert  (m_vert)
    );

    assign m_pos_x         = m_vert.pos_x;
    assign m_pos_y         = m_vert.pos_y;
    assign m_pos_z         = m_vert.pos_z;
    assign m_vert_u        = m_vert.vert_u;
    assign m_vert_v        = m_vert.vert_v;
    assign m_vert_color    = m_vert.vert_color;
    assign m_vertex_number = m_vert.vertex_number;
    assign m_tri_valid     = m_vert.tri_valid;
    assign m_tri_first     = m_vert.tri_first;
    assign m_tri_second    = m_vert.tri_second;
    assign m_tri_third     = m_vert.tri_third;
    assign m_last_corner   = m_vert.last_corner;

`ifndef ASSERT_OFF
    a_corner_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_corner |=> m_valid)
        else $error("Next corner of a quad was not ready after a transaction.");

    a_last_matches_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_last_corner == (m_vertex_number[1:0] == 2'b11))
        else $error("Last corner flag disagrees with the vertex number.");

    a_tri_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tri_valid |->
            m_tri_first[1:0] == 2'b00 && m_tri_first[VN_W-1:2] == m_vertex_number[VN_W-1:2])
        else $error("Triangle base is not the quad base of the vertex.");
`endif

endmodule

### src/bqg_front.sv
module bqg_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bqg_pkg::cam_cfg_t                     cam_cfg,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_batch_start,
    input  logic signed [bqg_pkg::POS_W-1:0]      s_center_x,
    input  logic signed [bqg_pkg::POS_W-1:0]      s_center_y,
    input  logic signed [bqg_pkg::POS_W-1:0]      s_center_z,
    input  logic [bqg_pkg::SIZE_W-1:0]            s_glyph_width,
    input  logic [bqg_pkg::SIZE_W-1:0]            s_glyph_height,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_u_left,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_v_bottom,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_u_right,
    input  logic [bqg_pkg::TEX_W-1:0]             s_tex_v_top,
    input  logic [bqg_pkg::COL_W-1:0]             s_color_rgba,
    output logic                                  fe_valid,
    input  logic                                  fe_ready,
    output bqg_pkg::glyph_rec_t                   fe_rec
);
    import bqg_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_eff;
    logic             keep;
    logic             s_acc;
    logic             push;
    logic             stg_valid_reg, stg_valid_next;
    glyph_rec_t       stg_reg;
    glyph_rec_t       rec_new;
    logic signed [SIZE_W:0] w_s, h_s;

    assign s_ready = !stg_valid_reg || fe_ready;
    assign s_acc   = s_valid && s_ready;
    assign push    = stg_valid_reg && fe_ready;

    assign cnt_eff = s_batch_start ? '0 : cnt_reg;
    assign keep    = cnt_eff < CNT_W'(MAX_GLYPHS);

    assign w_s = $signed({1'b0, s_glyph_width});
    assign h_s = $signed({1'b0, s_glyph_height});

    always_comb begin
        rec_new          = '0;
        rec_new.center_x = s_center_x;
        rec_new.center_y = s_center_y;
        rec_new.center_z = s_center_z;
        rec_new.prod_rx  = PROD_W'(cam_cfg.right_x) * PROD_W'(w_s);
        rec_new.prod_ry  = PROD_W'(cam_cfg.right_y) * PROD_W'(w_s);
        rec_new.prod_rz  = PROD_W'(cam_cfg.right_z) * PROD_W'(w_s);
        rec_new.prod_ux  = PROD_W'(cam_cfg.up_x) * PROD_W'(h_s);
        rec_new.prod_uy  = PROD_W'(cam_cfg.up_y) * PROD_W'(h_s);
        rec_new.prod_uz  = PROD_W'(cam_cfg.up_z) * PROD_W'(h_s);
        rec_new.tex_ul   = s_tex_u_left;
        rec_new.tex_vb   = s_tex_v_bottom;
        rec_new.tex_ur   = s_tex_u_right;
        rec_new.tex_vt   = s_tex_v_top;
        rec_new.color    = s_color_rgba;
        rec_new.base     = VN_W'({cnt_eff, 2'b00});
    end

    always_comb begin
        cnt_next       = cnt_reg;
        stg_valid_next = stg_valid_reg;
        if (push) begin
            stg_valid_next = 1'b0;
        end
        if (s_acc) begin
            cnt_next = keep ? cnt_eff + CNT_W'(1) : cnt_eff;
            if (keep) begin
                stg_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && keep) begin
            stg_reg <= rec_new;
        end
    end

    assign fe_valid = stg_valid_reg;
    assign fe_rec   = stg_reg;

endmodule

### src/bqg_queue.sv
module bqg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  bqg_pkg::glyph_rec_t in_rec,
    output logic                out_valid,
    input  logic                out_ready,
    output bqg_pkg::glyph_rec_t out_rec
);
    import bqg_pkg::*;

    glyph_rec_t        mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != (Q_AW+1)'(Q_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_rec   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (Q_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_rec;
        end
    end

endmodule

### src/bqg_back.sv
module bqg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  bqg_pkg::glyph_rec_t q_rec,
    output logic                m_valid,
    input  logic                m_ready,
    output bqg_pkg::vertex_t    m_vert
);
    import bqg_pkg::*;

    localparam int Q_W = ACC_W - FRAC_SHIFT;

    function automatic logic signed [POS_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] rnd;
        logic signed [Q_W-1:0]   q;
        logic [Q_W-POS_W:0]      top;
        rnd = acc + ACC_W'(ROUND_BIAS);
        q   = rnd[ACC_W-1:FRAC_SHIFT];
        top = q[Q_W-1:POS_W-1];
        if (top == '0 || top == '1) begin
            round_sat = q[POS_W-1:0];
        end else if (q[Q_W-1]) begin
            round_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] corner_sum(
        input logic signed [POS_W-1:0]  c,
        input logic signed [PROD_W-1:0] r,
        input logic signed [PROD_W-1:0] u,
        input logic                     r_neg,
        input logic                     u_neg
    );
        logic signed [ACC_W-1:0] ce, re, ue;
        ce = ACC_W'(c) <<< FRAC_SHIFT;
        re = ACC_W'(r);
        ue = ACC_W'(u);
        corner_sum = ce + (r_neg ? -re : re) + (u_neg ? -ue : ue);
    endfunction

    glyph_rec_t  cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [1:0]  corner_reg, corner_next;
    logic        out_valid_reg, out_valid_next;
    vertex_t     out_reg;
    vertex_t     vert;
    logic        adv, emit, done, r_neg, u_neg;

    assign adv     = !out_valid_reg || m_ready;
    assign emit    = adv && cur_valid_reg;
    assign done    = emit && corner_reg == CORNER_TL;
    assign q_ready = !cur_valid_reg || done;

    assign r_neg = corner_reg == CORNER_BL || corner_reg == CORNER_TL;
    assign u_neg = corner_reg == CORNER_BL || corner_reg == CORNER_BR;

    always_comb begin
        vert = '0;
        vert.pos_x = round_sat(corner_sum(cur_reg.center_x, cur_reg.prod_rx,
                                          cur_reg.prod_ux, r_neg, u_neg));
        vert.pos_y = round_sat(corner_sum(cur_reg.center_y, cur_reg.prod_ry,
                                          cur_reg.prod_uy, r_neg, u_neg));
        vert.pos_z = round_sat(corner_sum(cur_reg.center_z, cur_reg.prod_rz,
                                          cur_reg.prod_uz, r_neg, u_neg));
        vert.vert_u        = r_neg ? cur_reg.tex_ul : cur_reg.tex_ur;
        vert.vert_v        = u_neg ? cur_reg.tex_vb : cur_reg.tex_vt;
        vert.vert_color    = cur_reg.color;
        vert.vertex_number = cur_reg.base + VN_W'(corner_reg);
        vert.last_corner   = corner_reg == CORNER_TL;
        unique case (corner_reg)
            CORNER_BL: begin
                vert.tri_valid  = 1'b1;
                vert.tri_first  = cur_reg.base;
                vert.tri_second = cur_reg.base + VN_W'(1);
                vert.tri_third  = cur_reg.base + VN_W'(2);
            end
            CORNER_BR: begin
                vert.tri_valid  = 1'b1;
                vert.tri_first  = cur_reg.base;
                vert.tri_second = cur_reg.base + VN_W'(2);
                vert.tri_third  = cur_reg.base + VN_W'(3);
            end
            default: begin
                vert.tri_valid  = 1'b0;
                vert.tri_first  = '0;
                vert.tri_second = '0;
                vert.tri_third  = '0;
            end
        endcase
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = cur_valid_reg;
        end
        if (emit) begin
            corner_next = corner_reg + 2'd1;
        end
        if (done) begin
            cur_valid_next = 1'b0;
        end
        if (q_ready && q_valid) begin
            cur_valid_next = 1'b1;
            corner_next    = CORNER_BL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            corner_reg    <= CORNER_BL;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            cur_reg <= q_rec;
        end
        if (emit) begin
            out_reg <= vert;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_vert  = out_reg;

endmodule

### sim/quad_vertex_checker.sv
module quad_vertex_checker
    import bqg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_batch_start,
    input  logic signed [POS_W-1:0]  s_center_x,
    input  logic signed [POS_W-1:0]  s_center_y,
    input  logic signed [POS_W-1:0]  s_center_z,
    input  logic [SIZE_W-1:0]        s_glyph_width,
    input  logic [SIZE_W-1:0]        s_glyph_height,
    input  logic [TEX_W-1:0]         s_tex_u_left,
    input  logic [TEX_W-1:0]         s_tex_v_bottom,
    input  logic [TEX_W-1:0]         s_tex_u_right,
    input  logic [TEX_W-1:0]         s_tex_v_top,
    input  logic [COL_W-1:0]         s_color_rgba,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [POS_W-1:0]  m_pos_x,
    input  logic signed [POS_W-1:0]  m_pos_y,
    input  logic signed [POS_W-1:0]  m_pos_z,
    input  logic [TEX_W-1:0]         m_vert_u,
    input  logic [TEX_W-1:0]         m_vert_v,
    input  logic [COL_W-1:0]         m_vert_color,
    input  logic [VN_W-1:0]          m_vertex_number,
    input  logic                     m_tri_valid,
    input  logic [VN_W-1:0]          m_tri_first,
    input  logic [VN_W-1:0]          m_tri_second,
    input  logic [VN_W-1:0]          m_tri_third,
    input  logic                     m_last_corner,
    output int                       mismatch_total,
    output int                       vertices_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_MAX = 2147483647;
    localparam longint POS_MIN = -POS_MAX - 1;

    cam_cfg_t camera;
    int       glyph_count;
    int       error_count = 0;
    vertex_t  expected_vertices[$];

    function automatic logic signed [POS_W-1:0] round_to_q16(input longint acc);
        longint q;
        q = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
        if (q > POS_MAX) q = POS_MAX;
        if (q < POS_MIN) q = POS_MIN;
        return POS_W'(q);
    endfunction

    task automatic predict_quad();
        longint          cx, cy, cz, w, h, rs, us;
        logic [VN_W-1:0] base;
        vertex_t         v;
        if (s_batch_start) glyph_count = 0;
        if (glyph_count >= MAX_GLYPHS) return;
        cx = longint'(s_center_x) * 32768;
        cy = longint'(s_center_y) * 32768;
        cz = longint'(s_center_z) * 32768;
        w = longint'(s_glyph_width);
        h = longint'(s_glyph_height);
        base = VN_W'(glyph_count * 4);
        for (int k = 0; k < 4; k++) begin
            rs = (k == CORNER_BR || k == CORNER_TR) ? 1 : -1;
            us = (k == CORNER_TR || k == CORNER_TL) ? 1 : -1;
            v.pos_x = round_to_q16(cx + rs * longint'(camera.right_x) * w
                                      + us * longint'(camera.up_x) * h);
            v.pos_y = round_to_q16(cy + rs * longint'(camera.right_y) * w
                                      + us * longint'(camera.up_y) * h);
            v.pos_z = round_to_q16(cz + rs * longint'(camera.right_z) * w
                                      + us * longint'(camera.up_z) * h);
            v.vert_u = (rs < 0) ? s_tex_u_left : s_tex_u_right;
            v.vert_v = (us < 0) ? s_tex_v_bottom : s_tex_v_top;
            v.vert_color = s_color_rgba;
            v.vertex_number = base + VN_W'(k);
            v.tri_valid = 1'b0;
            v.tri_first = '0;
            v.tri_second = '0;
            v.tri_third = '0;
            if (k == CORNER_BL) begin
                v.tri_valid = 1'b1;
                v.tri_first = base;
                v.tri_second = base + VN_W'(1);
                v.tri_third = base + VN_W'(2);
            end else if (k == CORNER_BR) begin
                v.tri_valid = 1'b1;
                v.tri_first = base;
                v.tri_second = base + VN_W'(2);
                v.tri_third = base + VN_W'(3);
            end
            v.last_corner = (k == CORNER_TL);
            expected_vertices.push_back(v);
        end
        glyph_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%08h, got 0x%08h", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic check_vertex();
        vertex_t want;
        if (expected_vertices.size() == 0) begin
            $display("%0t: vertex %0d arrived with no glyph pending", $time, m_vertex_number);
            error_count++;
            return;
        end
        want = expected_vertices.pop_front();
        check_field("pos_x", want.pos_x, m_pos_x);
        check_field("pos_y", want.pos_y, m_pos_y);
        check_field("pos_z", want.pos_z, m_pos_z);
        check_field("vert_u", want.vert_u, m_vert_u);
        check_field("vert_v", want.vert_v, m_vert_v);
        check_field("vert_color", want.vert_color, m_vert_color);
        check_field("vertex_number", want.vertex_number, m_vertex_number);
        check_field("tri_valid", want.tri_valid, m_tri_valid);
        check_field("tri_first", want.tri_first, m_tri_first);
        check_field("tri_second", want.tri_second, m_tri_second);
        check_field("tri_third", want.tri_third, m_tri_third);
        check_field("last_corner", want.last_corner, m_last_corner);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            camera = '0;
            camera.right_x = UNIT_VEC;
            camera.up_y = UNIT_VEC;
            glyph_count = 0;
            expected_vertices.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RIGHT_X: camera.right_x = cfg_data;
                    REG_RIGHT_Y: camera.right_y = cfg_data;
                    REG_RIGHT_Z: camera.right_z = cfg_data;
                    REG_UP_X:    camera.up_x = cfg_data;
                    REG_UP_Y:    camera.up_y = cfg_data;
                    REG_UP_Z:    camera.up_z = cfg_data;
                    default:     ;
                endcase
            end
            if (s_valid && s_ready) predict_quad();
            if (m_valid && m_ready) check_vertex();
        end
        mismatch_total <= error_count;
        vertices_owed <= expected_vertices.size();
    end

endmodule

### sim/tb_billboard_quad_generator_core.sv
module tb_billboard_quad_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bqg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 31'h7FFF_FFFF;
    localparam int SRC_PLAN[4]  = '{0, 67, 0, 15};
    localparam int SINK_PLAN[4] = '{0, 0, 67, 15};

    typedef struct {
        logic                    batch_start;
        logic signed [POS_W-1:0] cx, cy, cz;
        logic [SIZE_W-1:0]       w, h;
        logic [TEX_W-1:0]        ul, vb, ur, vt;
        logic [COL_W-1:0]        color;
    } glyph_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_batch_start;
    logic signed [POS_W-1:0] s_center_x, s_center_y, s_center_z;
    logic [SIZE_W-1:0]       s_glyph_width, s_glyph_height;
    logic [TEX_W-1:0]        s_tex_u_left, s_tex_v_bottom, s_tex_u_right, s_tex_v_top;
    logic [COL_W-1:0]        s_color_rgba;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [POS_W-1:0] m_pos_x, m_pos_y, m_pos_z;
    logic [TEX_W-1:0]        m_vert_u, m_vert_v;
    logic [COL_W-1:0]        m_vert_color;
    logic [VN_W-1:0]         m_vertex_number;
    logic                    m_tri_valid;
    logic [VN_W-1:0]         m_tri_first, m_tri_second, m_tri_third;
    logic                    m_last_corner;

    int mismatch_total;
    int vertices_owed;
    int src_idle = 0;
    int sink_stall = 0;
    int cycle_count = 0;

    billboard_quad_generator_core uut (.*);

    quad_vertex_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall);
    end

    function automatic glyph_t make_glyph(input logic bs,
                                          input logic signed [POS_W-1:0] cx, cy, cz,
                                          input logic [SIZE_W-1:0] w, h,
                                          input logic [TEX_W-1:0] ul, vb, ur, vt,
                                          input logic [COL_W-1:0] color);
        glyph_t g;
        g.batch_start = bs;
        g.cx = cx;
        g.cy = cy;
        g.cz = cz;
        g.w = w;
        g.h = h;
        g.ul = ul;
        g.vb = vb;
        g.ur = ur;
        g.vt = vt;
        g.color = color;
        return g;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_coord();
        logic signed [POS_W-1:0] c;
        c = $urandom;
        if ($urandom_range(1)) c = c >>> $urandom_range(20, 4);
        return c;
    endfunction

    function automatic glyph_t rand_glyph(input int restart_pct);
        glyph_t g;
        g.batch_start = ($urandom_range(99) < restart_pct);
        g.cx = rand_coord();
        g.cy = rand_coord();
        g.cz = rand_coord();
        if ($urandom_range(3) == 0) begin
            g.w = SIZE_W'($urandom);
            g.h = SIZE_W'($urandom);
        end else begin
            g.w = SIZE_W'($urandom_range(32'h0040_0000));
            g.h = SIZE_W'($urandom_range(32'h0040_0000));
        end
        g.ul = TEX_W'($urandom);
        g.vb = TEX_W'($urandom);
        g.ur = TEX_W'($urandom);
        g.vt = TEX_W'($urandom);
        g.color = $urandom;
        return g;
    endfunction

    function automatic logic [CFG_W-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic send_glyph(input glyph_t g);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_batch_start <= g.batch_start;
        s_center_x <= g.cx;
        s_center_y <= g.cy;
        s_center_z <= g.cz;
        s_glyph_width <= g.w;
        s_glyph_height <= g.h;
        s_tex_u_left <= g.ul;
        s_tex_v_bottom <= g.vb;
        s_tex_u_right <= g.ur;
        s_tex_v_top <= g.vt;
        s_color_rgba <= g.color;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_camera_reg(input logic [CFG_IDX_W-1:0] index,
                                    input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_camera(input logic [CFG_W-1:0] coef, input bit scatter);
        for (int i = REG_RIGHT_X; i <= REG_UP_Z; i++) begin
            write_camera_reg(CFG_IDX_W'(i), scatter ? pick_coef() : coef);
        end
        write_camera_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, CFG_W'($urandom));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (vertices_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_extremes();
        send_glyph(make_glyph(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              SIZE_MAX, SIZE_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              32'hFFFF_FFFF));
        send_glyph(make_glyph(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              SIZE_MAX, SIZE_MAX, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                              32'h0000_0000));
        send_glyph(make_glyph(1'b0, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000,
                              31'd3, 31'd5, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                              32'hA5A5_5A5A));
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_batch_start <= 1'b0;
        s_center_x <= '0;
        s_center_y <= '0;
        s_center_z <= '0;
        s_glyph_width <= '0;
        s_glyph_height <= '0;
        s_tex_u_left <= '0;
        s_tex_v_bottom <= '0;
        s_tex_u_right <= '0;
        s_tex_v_top <= '0;
        s_color_rgba <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_glyph(make_glyph(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_extremes();
        send_glyph(make_glyph(1'b0, '0, '0, '0, 31'd1, 31'd1, 16'h0001, 16'h0002,
                              16'h0003, 16'h0004, 32'h1122_3344));
        send_glyph(make_glyph(1'b0, 32'sh0001_8000, -32'sh0002_4000, 32'sh7FFF_0000,
                              31'h0003_0000, 31'h0000_8000, 16'h1234, 16'h5678,
                              16'h9ABC, 16'hDEF0, 32'h89AB_CDEF));
        send_glyph(make_glyph(1'b1, -32'sd1, -32'sd1, -32'sd1, 31'd2, 31'd3, 16'h8000,
                              16'h7FFF, 16'h4000, 16'hC000, 32'h0102_0304));
        settle();

        load_camera(16'h7FFF, 1'b0);
        send_extremes();
        settle();
        load_camera(16'h8000, 1'b0);
        send_extremes();
        settle();
        load_camera(16'h0000, 1'b0);
        send_glyph(rand_glyph(0));
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            src_idle = SRC_PLAN[phase];
            sink_stall = SINK_PLAN[phase];
            load_camera(16'h0000, 1'b1);
            repeat (24) send_glyph(rand_glyph(6));
            settle();
        end

        if (mismatch_total == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### billboard_quad_generator_core.f
src/bqg_pkg.sv
src/bqg_front.sv
src/bqg_queue.sv
src/bqg_back.sv
src/billboard_quad_generator_core.sv
sim/quad_vertex_checker.sv
sim/tb_billboard_quad_generator_core.sv
